### rtl/core/soundex_word_matcher_assert.svh
// Assertion macros shared by the soundex word matcher RTL.
`ifndef SOUNDEX_WORD_MATCHER_ASSERT_SVH
`define SOUNDEX_WORD_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and held off during reset.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk and held off during reset.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWM_ASSERT_NOW(lbl, ante, cons, msg)
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/sdx_pkg.sv
// Package with the soundex letter table, field widths and register indexes.
`default_nettype none
package sdx_pkg;

    localparam int unsigned LetterWidth = 7;
    localparam int unsigned DigitWidth  = 3;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned OutWidth    = 24;  // 18 field bits padded to whole bytes

    localparam logic [ByteWidth-1:0] AsciiUpperA = 8'd65;
    localparam logic [ByteWidth-1:0] AsciiUpperZ = 8'd90;
    localparam logic [ByteWidth-1:0] AsciiLowerA = 8'd97;
    localparam logic [ByteWidth-1:0] AsciiLowerZ = 8'd122;
    localparam logic [ByteWidth-1:0] AsciiSpace  = 8'd32;
    localparam logic [ByteWidth-1:0] AsciiTab    = 8'd9;
    localparam logic [ByteWidth-1:0] AsciiCr     = 8'd13;
    localparam logic [ByteWidth-1:0] CaseOffset  = 8'd32;

    typedef enum logic [1:0] {
        REG_MATCH_LETTER  = 2'd0,
        REG_MATCH_DIGIT_A = 2'd1,
        REG_MATCH_DIGIT_B = 2'd2,
        REG_MATCH_DIGIT_C = 2'd3
    } cfg_index_t;

    // Soundex digit of a letter, given as its offset from A.
    function automatic logic [DigitWidth-1:0] letter_digit(input logic [4:0] idx);
        logic [DigitWidth-1:0] d;
        case (idx)
            5'd1, 5'd5, 5'd15, 5'd21:                       d = 3'd1; // B F P V
            5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23,
            5'd25:                                          d = 3'd2; // C G J K Q S X Z
            5'd3, 5'd19:                                    d = 3'd3; // D T
            5'd11:                                          d = 3'd4; // L
            5'd12, 5'd13:                                   d = 3'd5; // M N
            5'd17:                                          d = 3'd6; // R
            default:                                        d = 3'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### rtl/core/soundex_word_matcher.sv
// Top level of the soundex word matcher: byte stream in, one code beat per word out.
//
// Usage:
//   The slave stream takes header text one byte per beat: s_axis_tdata holds the
//   byte and s_axis_tlast marks the last byte of a text. Bytes split into words at
//   whitespace (space, tab, LF, VT, FF, CR) and at the last byte. Letters build the
//   word's soundex code; every other byte is dropped without ending the word.
//   At each word end one beat leaves on the master stream with the word's code,
//   whether it equals the configured match code, and a sticky any-hit flag for the
//   text. The last byte of a text always yields a beat, with m_axis_tlast set.
//   The match code is loaded through cfg_we / cfg_index / cfg_data while idle.
// Timing:
//   A taken byte is worked on from the input register; its beat is registered in the
//   output register that drives m_axis_tvalid. One byte per clock is taken, set by the
//   single pass through the letter table and compares, unless a held beat blocks a result.
// Reset and stalls:
//   rst_n clears the word state, the sticky flag and both stage valids, and loads
//   the match code A000. When the receiver holds m_axis_tready low, the output
//   beat is held; bytes that give no result still drain, and the input stops only
//   once a result-producing byte waits behind the held beat.
`default_nettype none
`include "soundex_word_matcher_assert.svh"
module soundex_word_matcher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    // Byte input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // end_of_text
    // Word result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [sdx_pkg::OutWidth-1:0] m_axis_tdata,
                                             // [6:0] word_letter, [9:7] word_digit_a,
                                             // [12:10] word_digit_b, [15:13] word_digit_c,
                                             // [16] word_hit, [17] any_hit, [23:18] zero
    output logic             m_axis_tlast    // text_done
);

    localparam int unsigned LW = sdx_pkg::LetterWidth;
    localparam int unsigned DW = sdx_pkg::DigitWidth;

    // Match code registers.
    logic [LW-1:0] match_letter_reg;
    logic [DW-1:0] match_digit_a_reg;
    logic [DW-1:0] match_digit_b_reg;
    logic [DW-1:0] match_digit_c_reg;

    // Input register.
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;

    // Word state.
    logic          word_open_reg,    word_open_next;
    logic [LW-1:0] first_letter_reg, first_letter_next;
    logic [DW-1:0] prev_digit_reg,   prev_digit_next;
    logic [1:0]    digit_count_reg,  digit_count_next;
    logic [DW-1:0] digit_a_reg,      digit_a_next;
    logic [DW-1:0] digit_b_reg,      digit_b_next;
    logic [DW-1:0] digit_c_reg,      digit_c_next;
    logic          hit_seen_reg,     hit_seen_next;

    // Output register.
    logic          out_valid_reg;
    logic [sdx_pkg::OutWidth-1:0] out_data_reg, out_data_next;
    logic          out_last_reg;

    logic          emit;
    logic          in_move;
    logic          out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_letter_reg  <= LW'(sdx_pkg::AsciiUpperA);
            match_digit_a_reg <= '0;
            match_digit_b_reg <= '0;
            match_digit_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (sdx_pkg::cfg_index_t'(cfg_index))
                sdx_pkg::REG_MATCH_LETTER:  match_letter_reg  <= cfg_data;
                sdx_pkg::REG_MATCH_DIGIT_A: match_digit_a_reg <= cfg_data[DW-1:0];
                sdx_pkg::REG_MATCH_DIGIT_B: match_digit_b_reg <= cfg_data[DW-1:0];
                sdx_pkg::REG_MATCH_DIGIT_C: match_digit_c_reg <= cfg_data[DW-1:0];
            endcase
        end
    end

    // The held byte moves on when it yields no beat or the output slot is free.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_move       = in_valid_reg && (!emit || out_free);
    assign s_axis_tready = !in_valid_reg || in_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Letter folding, word tracking and matching for the held byte.
    always_comb
    begin
        logic          is_upper;
        logic          is_lower;
        logic          is_letter;
        logic          is_sep;
        logic          ends;
        logic [7:0]    up_byte;
        logic [7:0]    offset;
        logic [DW-1:0] d;
        logic          open1;
        logic [LW-1:0] first1;
        logic [DW-1:0] prev1;
        logic [1:0]    cnt1;
        logic [DW-1:0] da1;
        logic [DW-1:0] db1;
        logic [DW-1:0] dc1;
        logic          hit;
        logic          any;

        is_upper  = in_byte_reg >= sdx_pkg::AsciiUpperA && in_byte_reg <= sdx_pkg::AsciiUpperZ;
        is_lower  = in_byte_reg >= sdx_pkg::AsciiLowerA && in_byte_reg <= sdx_pkg::AsciiLowerZ;
        is_letter = is_upper || is_lower;
        is_sep    = in_byte_reg == sdx_pkg::AsciiSpace ||
                    (in_byte_reg >= sdx_pkg::AsciiTab && in_byte_reg <= sdx_pkg::AsciiCr);
        up_byte   = is_lower ? in_byte_reg - sdx_pkg::CaseOffset : in_byte_reg;
        offset    = up_byte - sdx_pkg::AsciiUpperA;
        d         = sdx_pkg::letter_digit(offset[4:0]);

        open1  = word_open_reg;
        first1 = first_letter_reg;
        prev1  = prev_digit_reg;
        cnt1   = digit_count_reg;
        da1    = digit_a_reg;
        db1    = digit_b_reg;
        dc1    = digit_c_reg;

        if (is_letter)
        begin
            if (!word_open_reg)
            begin
                // The first letter's own digit only seeds the repeat check.
                open1  = 1'b1;
                first1 = up_byte[LW-1:0];
                prev1  = d;
            end
            else if (d != '0)
            begin
                if (d != prev_digit_reg && digit_count_reg != 2'd3)
                begin
                    case (digit_count_reg)
                        2'd0:    da1 = d;
                        2'd1:    db1 = d;
                        default: dc1 = d;
                    endcase
                    cnt1 = digit_count_reg + 2'd1;
                end
                prev1 = d;
            end
        end

        ends = in_last_reg || is_sep;
        emit = in_valid_reg && ends && (open1 || in_last_reg);

        hit = open1 && first1 == match_letter_reg && da1 == match_digit_a_reg &&
              db1 == match_digit_b_reg && dc1 == match_digit_c_reg;
        any = hit_seen_reg || hit;

        // Word fields are already zero when no word is open.
        out_data_next = {6'd0, any, hit, dc1, db1, da1, first1};

        if (ends)
        begin
            word_open_next    = 1'b0;
            first_letter_next = '0;
            prev_digit_next   = '0;
            digit_count_next  = '0;
            digit_a_next      = '0;
            digit_b_next      = '0;
            digit_c_next      = '0;
        end
        else
        begin
            word_open_next    = open1;
            first_letter_next = first1;
            prev_digit_next   = prev1;
            digit_count_next  = cnt1;
            digit_a_next      = da1;
            digit_b_next      = db1;
            digit_c_next      = dc1;
        end

        if (in_last_reg)
        begin
            hit_seen_next = 1'b0;
        end
        else if (ends)
        begin
            hit_seen_next = any;
        end
        else
        begin
            hit_seen_next = hit_seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_open_reg    <= 1'b0;
            first_letter_reg <= '0;
            prev_digit_reg   <= '0;
            digit_count_reg  <= '0;
            digit_a_reg      <= '0;
            digit_b_reg      <= '0;
            digit_c_reg      <= '0;
            hit_seen_reg     <= 1'b0;
        end
        else if (in_move)
        begin
            word_open_reg    <= word_open_next;
            first_letter_reg <= first_letter_next;
            prev_digit_reg   <= prev_digit_next;
            digit_count_reg  <= digit_count_next;
            digit_a_reg      <= digit_a_next;
            digit_b_reg      <= digit_b_next;
            digit_c_reg      <= digit_c_next;
            hit_seen_reg     <= hit_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_move && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move && emit)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `SWM_ASSERT_NEXT(a_hit_clears_at_text_end, in_move && in_last_reg, !hit_seen_reg,
        "sticky hit flag survived the end of a text")
    `SWM_ASSERT_NOW(a_word_hit_sets_any, m_axis_tvalid && m_axis_tdata[16],
        m_axis_tdata[17], "word hit reported without any-hit")
    `SWM_ASSERT_NOW(a_closed_word_is_empty, !word_open_reg,
        digit_count_reg == 2'd0 && first_letter_reg == '0, "closed word holds state")
    `SWM_ASSERT_NOW(a_unused_digit_zero, digit_count_reg != 2'd3, digit_c_reg == '0,
        "third digit set before three digits were counted")

endmodule
`default_nettype wire

### tb/sv/tb_soundex_word_matcher.sv
// Self-checking testbench for the soundex word matcher: byte stream in, word codes checked out.
`timescale 1ns / 1ps
module tb_soundex_word_matcher;

    // Margin after the last code has come out, which lets bytes that give no
    // result drain before the match code changes.
    localparam int SETTLE_CYCLES = 6;
    // Cycles in a row with no beat on either side before the run is declared hung.
    localparam int STALL_LIMIT   = 3000;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 300;
    localparam int IDLE_PERCENT  = 7;
    localparam int MAX_REPORTS   = 10;
    localparam int POOL_SIZE     = 8;

    // One input beat: the byte and the end-of-text mark.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_beat_t;

    // One result beat. The layout matches {m_axis_tlast, m_axis_tdata[17:0]}.
    typedef struct packed {
        logic       text_done;
        logic       any_hit;
        logic       word_hit;
        logic [2:0] digit_c;
        logic [2:0] digit_b;
        logic [2:0] digit_a;
        logic [6:0] letter;
    } word_code_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    sdx_pkg::cfg_index_t cfg_index = sdx_pkg::REG_MATCH_LETTER;
    logic [6:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    soundex_word_matcher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] text_byte
        .s_axis_tlast  (s_axis_tlast),   // end_of_text
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [6:0] letter, [9:7] a, [12:10] b, [15:13] c,
                                         // [16] word_hit, [17] any_hit, [23:18] zero
        .m_axis_tlast  (m_axis_tlast)    // text_done
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bytes waiting to be offered, and word codes waiting to come out.
    text_beat_t text_bytes[$];
    word_code_t expected_words[$];

    // Copy of the match code as last written.
    logic [6:0] want_letter = 7'd65;
    logic [2:0] want_a = '0;
    logic [2:0] want_b = '0;
    logic [2:0] want_c = '0;

    // Copy of the word state of the block.
    logic       open_word = 1'b0;
    logic [6:0] lead_letter = '0;
    logic [2:0] last_digit = '0;
    logic [1:0] held_digits = '0;
    logic [2:0] word_digits [3] = '{3'd0, 3'd0, 3'd0};
    logic       text_hit = 1'b0;

    // Handshake bookkeeping shared between the processes.
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;
    int queued_count = 0;
    int bytes_taken = 0;
    int beats_seen = 0;
    int words_checked = 0;
    int word_hits = 0;
    int texts_closed = 0;
    int mismatches = 0;

    // Known words that texts draw on; several match settings are taken from their codes.
    string word_pool [POOL_SIZE] = '{"ROBERT", "TYMCZAK", "PFISTER", "ASHCRAFT",
                                     "LEE", "GUTIERREZ", "HONEYMAN", "AHOY"};

    // Soundex digit of an uppercase letter; vowels, H, W and Y give zero.
    function automatic logic [2:0] digit_of(input logic [6:0] up);
        logic [2:0] d;
        case (up)
            "B", "F", "P", "V":                     d = 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z": d = 3'd2;
            "D", "T":                               d = 3'd3;
            "L":                                    d = 3'd4;
            "M", "N":                               d = 3'd5;
            "R":                                    d = 3'd6;
            default:                                d = 3'd0;
        endcase
        return d;
    endfunction

    function automatic bit is_separator(input logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
    endfunction

    // Runs one accepted byte through the word state and queues the code of a
    // finished word. A letter on the last byte joins the word before it ends.
    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [6:0] up;
        logic [2:0] d;
        logic       hit;
        word_code_t code;
        if (is_letter(b))
        begin
            up = (b >= 8'd97) ? 7'(b - 8'd32) : b[6:0];
            d = digit_of(up);
            if (!open_word)
            begin
                // The first letter's digit only seeds the repeat filter.
                open_word = 1'b1;
                lead_letter = up;
                last_digit = d;
            end
            else if (d != 3'd0)
            begin
                if (d != last_digit && held_digits < 2'd3)
                begin
                    word_digits[held_digits] = d;
                    held_digits = held_digits + 2'd1;
                end
                last_digit = d;
            end
        end
        if ((last || is_separator(b)) && (open_word || last))
        begin
            code = '0;
            if (open_word)
            begin
                hit = lead_letter == want_letter && word_digits[0] == want_a &&
                      word_digits[1] == want_b && word_digits[2] == want_c;
                if (hit)
                    text_hit = 1'b1;
                code.letter = lead_letter;
                code.digit_a = word_digits[0];
                code.digit_b = word_digits[1];
                code.digit_c = word_digits[2];
                code.word_hit = hit;
            end
            // A last byte with no word open still closes the text with one beat that carries the sticky flag.
            code.any_hit = text_hit;
            code.text_done = last;
            expected_words.push_back(code);
            open_word = 1'b0;
            lead_letter = '0;
            last_digit = '0;
            held_digits = '0;
            word_digits = '{3'd0, 3'd0, 3'd0};
            if (last)
                text_hit = 1'b0;
        end
    endtask

    // Compares one result beat with the oldest expected code.
    task automatic check_word_beat(input word_code_t got);
        word_code_t want;
        beats_seen++;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("beat %0d: result with no word pending, got %h", beats_seen, got);
        end
        else
        begin
            want = expected_words.pop_front();
            if (want.letter != 0)
                words_checked++;
            if (want.word_hit)
                word_hits++;
            if (want.text_done)
                texts_closed++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("beat %0d: expected %c%0d%0d%0d hit %b any %b done %b,",
                             beats_seen, want.letter, want.digit_a, want.digit_b,
                             want.digit_c, want.word_hit, want.any_hit, want.text_done);
                    $display("    got %c%0d%0d%0d hit %b any %b done %b",
                             got.letter, got.digit_a, got.digit_b, got.digit_c,
                             got.word_hit, got.any_hit, got.text_done);
                end
            end
        end
    endtask

    // Monitor: both handshakes are sampled at the rising edge. Bytes are
    // predicted before results are checked, so a beat always finds its code.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken = s_axis_tvalid && s_axis_tready;
            out_taken = m_axis_tvalid && m_axis_tready;
            if (in_taken)
            begin
                bytes_taken++;
                encode_byte(s_axis_tdata, s_axis_tlast);
            end
            if (out_taken)
                check_word_beat({m_axis_tlast, m_axis_tdata[17:0]});
            if (in_taken || out_taken)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Driver: a beat stays on the bus until it is taken; a new one may follow
    // without a gap, and gaps are inserted at random unless the run is quiet.
    always @(negedge clk)
    begin
        text_beat_t beat;
        logic       next_valid;
        logic [7:0] next_data;
        logic       next_last;
        next_valid = s_axis_tvalid;
        next_data = s_axis_tdata;
        next_last = s_axis_tlast;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            next_valid = 1'b0;
            if (text_bytes.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT))
            begin
                beat = text_bytes.pop_front();
                next_valid = 1'b1;
                next_data = beat.text_byte;
                next_last = beat.end_of_text;
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata <= next_data;
        s_axis_tlast <= next_last;
    end

    // Receiver: random back-pressure, plus one long hold-off on request that
    // lets the block fill up and stop taking bytes.
    always @(negedge clk)
    begin
        logic next_ready;
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!rst_n)
            next_ready = 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            next_ready = 1'b0;
        end
        else
            next_ready = quiet || $urandom_range(99) >= IDLE_PERCENT;
        m_axis_tready <= next_ready;
    end

    // Watchdog on cycles in which no beat moves on either side.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic add_byte(input logic [7:0] b, input logic last);
        text_beat_t beat;
        beat.text_byte = b;
        beat.end_of_text = last;
        text_bytes.push_back(beat);
        queued_count++;
    endtask

    // Pushes the bytes of a string unchanged, none of them marked last.
    task automatic add_raw(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] random_separator();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    // Any byte that is neither a letter nor whitespace, high bytes included.
    function automatic logic [7:0] random_noise();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_letter(b) || is_separator(b))
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // Adds a letter in random case, now and then followed by a dropped byte.
    task automatic add_letter(input logic [7:0] up);
        add_byte($urandom_range(1) ? (up | 8'h20) : up, 1'b0);
        if ($urandom_range(99) < 8)
            add_byte(random_noise(), 1'b0);
    endtask

    // One text: up to five words, mostly the search word or other known words,
    // split by whitespace runs, closed in one of several ways.
    task automatic add_text(input string target);
        int    nwords;
        int    w;
        int    i;
        int    pick;
        string word;
        nwords = $urandom_range(0, 5);
        for (w = 0; w < nwords; w++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                word = (pick < 35) ? target : word_pool[$urandom_range(POOL_SIZE - 1)];
                for (i = 0; i < word.len(); i++)
                    add_letter(word[i]);
            end
            else
                repeat ($urandom_range(1, 8))
                    add_letter(8'($urandom_range(65, 90)));
            if (w != nwords - 1)
                repeat ($urandom_range(1, 3))
                    add_byte(random_separator(), 1'b0);
        end
        pick = $urandom_range(99);
        if (pick < 30)
            add_byte(8'($urandom_range(65, 90)) | (8'($urandom_range(1)) << 5), 1'b1);
        else if (pick < 60)
            add_byte(random_separator(), 1'b1);
        else if (pick < 75)
            add_byte(random_noise(), 1'b1);
        else
        begin
            // The word closes first, so the last byte finds no word open.
            add_byte(random_separator(), 1'b0);
            add_byte($urandom_range(1) ? random_separator() : random_noise(), 1'b1);
        end
    endtask

    task automatic write_reg(input sdx_pkg::cfg_index_t idx, input logic [6:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            sdx_pkg::REG_MATCH_LETTER:  want_letter = value;
            sdx_pkg::REG_MATCH_DIGIT_A: want_a = value[2:0];
            sdx_pkg::REG_MATCH_DIGIT_B: want_b = value[2:0];
            sdx_pkg::REG_MATCH_DIGIT_C: want_c = value[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_match_code(input logic [6:0] letter,
                                  input logic [2:0] da, input logic [2:0] db,
                                  input logic [2:0] dc);
        write_reg(sdx_pkg::REG_MATCH_LETTER, letter);
        write_reg(sdx_pkg::REG_MATCH_DIGIT_A, {4'd0, da});
        write_reg(sdx_pkg::REG_MATCH_DIGIT_B, {4'd0, db});
        write_reg(sdx_pkg::REG_MATCH_DIGIT_C, {4'd0, dc});
    endtask

    // Waits until every byte is taken and every code has come out, then lets
    // the pipeline settle so that bytes without a result have left it too.
    task automatic wait_until_drained();
        while (bytes_taken != queued_count || expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // One random phase under a given match code.
    task automatic run_phase(input string target, input logic [6:0] letter,
                             input logic [2:0] da, input logic [2:0] db,
                             input logic [2:0] dc, input bit with_hold, input bit no_idle);
        int first;
        set_match_code(letter, da, db, dc);
        @(posedge clk);
        quiet = no_idle;
        hold_request = with_hold;
        first = queued_count;
        while (queued_count - first < PHASE_ITEMS)
            add_text(target);
        wait_until_drained();
        @(posedge clk);
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed text under the code R163. Two spellings hit, a later word
        // misses while the sticky flag holds, dropped bytes and whitespace with
        // no word give nothing, a letter on the last byte forms its own word,
        // and a text made of one whitespace byte closes with an empty beat.
        set_match_code("R", 3'd1, 3'd6, 3'd3);
        add_raw("Robert");
        add_byte(8'd13, 1'b0);
        add_raw("rUp'ert");
        add_byte(8'd9, 1'b0);
        add_raw("Lee ");
        add_byte(8'd128, 1'b0);
        add_byte(8'd255, 1'b0);
        add_byte(8'd0, 1'b0);
        add_byte(8'd10, 1'b0);
        add_byte(8'd11, 1'b0);
        add_byte("Z", 1'b1);
        add_byte(8'd12, 1'b1);
        wait_until_drained();

        // Random phases: ordinary codes, the lowest and highest legal settings,
        // one setting outside the legal range, one long receiver hold-off and
        // one stretch with no idling on either side.
        run_phase("TYMCZAK", "T", 3'd5, 3'd2, 3'd0, 1'b0, 1'b0);
        run_phase("AHOY", "A", 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
        run_phase("GUTIERREZ", "Z", 3'd6, 3'd6, 3'd6, 1'b1, 1'b0);
        run_phase("ROBERT", 7'd127, 3'd7, 3'd7, 3'd7, 1'b0, 1'b1);
        run_phase("ASHCRAFT", "A", 3'd2, 3'd6, 3'd1, 1'b0, 1'b0);
        run_phase("GUTIERREZ", "G", 3'd3, 3'd6, 3'd2, 1'b0, 1'b0);

        $display("Run covered %0d text bytes, %0d words and %0d closed texts.",
                 bytes_taken, words_checked, texts_closed);
        $display("%0d words matched across 7 match codes; %0d beats differed.",
                 word_hits, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
